// ----- design/yolo_grid_cell_decoder_macros.svh -----
// ---------------------------------------------------------------------------
// yolo grid cell decoder assertion macros
// shared concurrent assertion forms for the decoder modules
// ---------------------------------------------------------------------------
`ifndef YOLO_GRID_CELL_DECODER_MACROS_SVH
`define YOLO_GRID_CELL_DECODER_MACROS_SVH

// condition must never hold out of reset
`define YGCD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// antecedent implies consequent on the next cycle
`define YGCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/ygcd_pkg.sv -----
// ---------------------------------------------------------------------------
// ygcd_pkg
// types, tables and register codes of the grid cell decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ygcd_pkg;

  localparam logic [2:0] CFG_OBJ_THR     = 3'd0;
  localparam logic [2:0] CFG_CONF_THR    = 3'd1;
  localparam logic [2:0] CFG_CLASS_COUNT = 3'd2;
  localparam logic [2:0] CFG_RATIO_W     = 3'd3;
  localparam logic [2:0] CFG_RATIO_H     = 3'd4;

  localparam logic [15:0] SIG_TAB [17] = '{
    16'd32768, 16'd40794, 16'd47910, 16'd53581, 16'd57724, 16'd60565,
    16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
    16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
  };

  localparam logic [9:0] ANCHOR_ROM [4][6] = '{
    '{10'd10,  10'd13,  10'd16,  10'd30,  10'd33,  10'd23},
    '{10'd30,  10'd61,  10'd62,  10'd45,  10'd59,  10'd119},
    '{10'd116, 10'd90,  10'd156, 10'd198, 10'd373, 10'd326},
    '{10'd436, 10'd615, 10'd739, 10'd380, 10'd925, 10'd792}
  };

  typedef struct packed {
    logic [15:0] cx_prob;
    logic [15:0] cy_prob;
    logic [15:0] w_prob;
    logic [15:0] h_prob;
    logic [15:0] best_prob;
    logic [7:0]  best_class;
    logic [7:0]  grid_col;
    logic [7:0]  grid_row;
    logic [1:0]  scale;
    logic [1:0]  anchor;
  } ygcd_job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SQ, BK_ANC, BK_EDGE, BK_MUL, BK_FIN, BK_DONE
  } ygcd_back_state_t;

endpackage
`default_nettype wire

// ----- design/ygcd_front.sv -----
// ---------------------------------------------------------------------------
// ygcd_front
// sigmoid per logit, channel tracking, best class search, cell qualification
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ygcd_front #(
  parameter int MAX_CLASSES = 80,
  parameter int NUM_SCALES  = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire logic signed [15:0] logit_value,
  input  wire logic [7:0]        grid_col,
  input  wire logic [7:0]        grid_row,
  input  wire logic [1:0]        scale_index,
  input  wire logic [1:0]        anchor_index,
  input  wire logic              cell_end,
  input  wire logic [15:0]       obj_thr,
  input  wire logic [15:0]       conf_thr,
  input  wire logic [7:0]        class_count,
  output logic                   job_push,
  output ygcd_pkg::ygcd_job_t    job
);
  import ygcd_pkg::*;

  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] cx_r, cy_r, w_r, h_r, obj_r, best_r;
  logic [7:0]  bcls_r;
  logic        neg, big;
  logic [16:0] mag;
  logic [3:0]  seg;
  logic [8:0]  frac;
  logic [15:0] t0, t1, diff;
  logic [24:0] prod;
  logic [16:0] interp, v, vn;
  logic [15:0] s;
  logic [7:0]  cnt, cls;
  logic        take;
  logic [15:0] obj_nxt, best_nxt;
  logic [7:0]  bcls_nxt;

  always_comb begin
    neg    = logit_value[15];
    mag    = neg ? 17'(17'd65536 - {1'b0, logit_value}) : {1'b0, logit_value};
    big    = mag >= 17'd8192;
    seg    = mag[12:9];
    frac   = mag[8:0];
    t0     = SIG_TAB[{1'b0, seg}];
    t1     = SIG_TAB[5'({1'b0, seg}) + 5'd1];
    diff   = t1 - t0;
    prod   = 25'(diff) * 25'(frac);
    interp = {1'b0, t0} + 17'(prod >> 9);
    v      = big ? 17'd65535 : interp;
    vn     = neg ? 17'(17'd65536 - v) : v;
    s      = (vn > 17'd65535) ? 16'hffff : vn[15:0];

    cnt  = (class_count < 8'(MAX_CLASSES)) ? class_count : 8'(MAX_CLASSES);
    cls  = pos_r - 8'd5;
    take = (pos_r >= 8'd5) && (cls < cnt) && ((pos_r == 8'd5) || (s > best_r));
    best_nxt = take ? s : best_r;
    bcls_nxt = take ? cls : bcls_r;
    obj_nxt  = (pos_r == 8'd4) ? s : obj_r;
    pos_nxt  = (pos_r == 8'hff) ? 8'hff : pos_r + 8'd1;

    job_push = item_valid && cell_end && (pos_nxt > 8'd5) && (cnt != 8'd0) &&
               (obj_nxt > obj_thr) && (best_nxt > conf_thr);

    job.cx_prob    = cx_r;
    job.cy_prob    = cy_r;
    job.w_prob     = w_r;
    job.h_prob     = h_r;
    job.best_prob  = best_nxt;
    job.best_class = bcls_nxt;
    job.grid_col   = grid_col;
    job.grid_row   = grid_row;
    job.scale      = ({1'b0, scale_index} >= 3'(NUM_SCALES)) ? 2'(NUM_SCALES - 1)
                                                             : scale_index;
    job.anchor     = (anchor_index == 2'd3) ? 2'd2 : anchor_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      w_r    <= '0;
      h_r    <= '0;
      obj_r  <= '0;
      best_r <= '0;
      bcls_r <= '0;
    end else if (item_valid) begin
      if (pos_r == 8'd0) cx_r <= s;
      if (pos_r == 8'd1) cy_r <= s;
      if (pos_r == 8'd2) w_r  <= s;
      if (pos_r == 8'd3) h_r  <= s;
      obj_r <= obj_nxt;
      if (cell_end) begin
        pos_r  <= '0;
        best_r <= '0;
        bcls_r <= '0;
      end else begin
        pos_r  <= pos_nxt;
        best_r <= best_nxt;
        bcls_r <= bcls_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/ygcd_queue.sv -----
// ---------------------------------------------------------------------------
// ygcd_queue
// two-entry queue of qualified cells between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ygcd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_i,
  input  ygcd_pkg::ygcd_job_t      wdata,
  input  wire logic                pop_i,
  output ygcd_pkg::ygcd_job_t      rdata,
  output logic                     empty_o,
  output logic                     full_o
);
  import ygcd_pkg::*;
  `include "yolo_grid_cell_decoder_macros.svh"

  ygcd_job_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign empty_o = (cnt_r == 2'd0);
  assign full_o  = (cnt_r == 2'd2);
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push_i) wr_ptr_r <= ~wr_ptr_r;
      if (pop_i) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push_i) - 2'(pop_i);
    end
  end

  `YGCD_ASSERT_NEVER(a_no_overflow, clk, rst_n, push_i && full_o && !pop_i)
  `YGCD_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop_i && empty_o)
  `YGCD_ASSERT_NEXT(a_fill_one, clk, rst_n, push_i && !pop_i && empty_o, cnt_r == 2'd1)

endmodule
`default_nettype wire

// ----- design/ygcd_back.sv -----
// ---------------------------------------------------------------------------
// ygcd_back
// box arithmetic sequencer and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ygcd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  ygcd_pkg::ygcd_job_t      q_job,
  output logic                     q_pop,
  input  wire logic [15:0]         ratio_w,
  input  wire logic [15:0]         ratio_h,
  input  wire logic                res_pop,
  output logic                     res_valid,
  output logic [7:0]               class_id,
  output logic [15:0]              class_score,
  output logic signed [15:0]       box_left,
  output logic signed [15:0]       box_top,
  output logic [15:0]              box_width,
  output logic [15:0]              box_height
);
  import ygcd_pkg::*;

  ygcd_back_state_t state_r, state_nxt;
  ygcd_job_t        job_r;
  logic [1:0]       idx_r;
  logic [31:0]      wsq_r, hsq_r;
  logic [43:0]      wq_r, hq_r;
  logic signed [32:0] cxq_r, cyq_r;
  logic signed [48:0] left_r, top_r;
  logic signed [41:0] phi_r;
  logic [39:0]        plo_r;
  logic signed [15:0] rl_r, rt_r;
  logic [15:0]        rw_r, rh_r;
  logic               out_valid_r;

  logic [9:0]         aw, ah;
  logic signed [26:0] bx, by;
  logic [2:0]         shamt;
  logic signed [48:0] opnd;
  logic [15:0]        ratio;
  logic signed [24:0] hi;
  logic [23:0]        lo;
  logic signed [16:0] rs;
  logic signed [41:0] phi;
  logic [39:0]        plo;
  logic signed [65:0] sum, adj, q;
  logic signed [15:0] edge_val;
  logic [15:0]        size_val;
  logic               load_out;

  always_comb begin
    aw    = ANCHOR_ROM[job_r.scale][{job_r.anchor, 1'b0}];
    ah    = ANCHOR_ROM[job_r.scale][{job_r.anchor, 1'b1}];
    bx    = $signed({10'b0, job_r.cx_prob, 1'b0}) - 27'sd32768
          + $signed({3'b0, job_r.grid_col, 16'b0});
    by    = $signed({10'b0, job_r.cy_prob, 1'b0}) - 27'sd32768
          + $signed({3'b0, job_r.grid_row, 16'b0});
    shamt = {1'b0, job_r.scale} + 3'd3;
    unique case (idx_r)
      2'd0:    opnd = left_r;
      2'd1:    opnd = top_r;
      2'd2:    opnd = $signed({5'b0, wq_r});
      default: opnd = $signed({5'b0, hq_r});
    endcase
    ratio = idx_r[0] ? ratio_h : ratio_w;
    hi    = opnd[48:24];
    lo    = opnd[23:0];
    rs    = $signed({1'b0, ratio});
    phi   = hi * rs;
    plo   = 40'(lo) * 40'(ratio);
    sum   = (66'(phi_r) <<< 24) + $signed({26'b0, plo_r});
    adj   = (sum < 0) ? sum + 66'sd1099511627775 : sum;
    q     = adj >>> 40;
    if (q > 66'sd32767) edge_val = 16'sh7fff;
    else if (q < -66'sd32768) edge_val = -16'sh8000;
    else edge_val = q[15:0];
    size_val = (q > 66'sd65535) ? 16'hffff : q[15:0];
    load_out = (state_r == BK_DONE) && (!out_valid_r || res_pop);
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_SQ;
        end
      end
      BK_SQ:   state_nxt = BK_ANC;
      BK_ANC:  state_nxt = BK_EDGE;
      BK_EDGE: state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_FIN;
      BK_FIN:  state_nxt = (idx_r == 2'd3) ? BK_DONE : BK_MUL;
      BK_DONE: begin
        if (load_out) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_EDGE) idx_r <= '0;
      else if (state_r == BK_FIN) idx_r <= idx_r + 2'd1;
      if (load_out) out_valid_r <= 1'b1;
      else if (res_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    if (state_r == BK_SQ) begin
      wsq_r <= 32'(job_r.w_prob) * 32'(job_r.w_prob);
      hsq_r <= 32'(job_r.h_prob) * 32'(job_r.h_prob);
    end
    if (state_r == BK_ANC) begin
      wq_r  <= {42'(wsq_r) * 42'(aw), 2'b00};
      hq_r  <= {42'(hsq_r) * 42'(ah), 2'b00};
      cxq_r <= 33'(bx) <<< shamt;
      cyq_r <= 33'(by) <<< shamt;
    end
    if (state_r == BK_EDGE) begin
      left_r <= $signed({cxq_r, 16'b0}) - $signed({6'b0, wq_r[43:1]});
      top_r  <= $signed({cyq_r, 16'b0}) - $signed({6'b0, hq_r[43:1]});
    end
    if (state_r == BK_MUL) begin
      phi_r <= phi;
      plo_r <= plo;
    end
    if (state_r == BK_FIN) begin
      unique case (idx_r)
        2'd0:    rl_r <= edge_val;
        2'd1:    rt_r <= edge_val;
        2'd2:    rw_r <= size_val;
        default: rh_r <= size_val;
      endcase
    end
    if (load_out) begin
      class_id    <= job_r.best_class;
      class_score <= job_r.best_prob;
      box_left    <= rl_r;
      box_top     <= rt_r;
      box_width   <= rw_r;
      box_height  <= rh_r;
    end
  end

  assign res_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- design/yolo_grid_cell_decoder.sv -----
// ---------------------------------------------------------------------------
// yolo_grid_cell_decoder
// decodes grid cells from a logit stream into thresholded boxes
//
// channel  ports                         transfer
// input    push / full, in_*             push && !full
// result   empty / pop, out_*            pop && !empty
// config   cfg_we, cfg_index, cfg_wdata  cfg_we
//
// one logit a cycle into the front while the cell queue has room
// each qualifying cell holds the back through its shared
// box multiply sequence; the two-entry queue absorbs short cells
// with back idle a cell runs queue, SQ, ANC, EDGE, MUL/FIN per value, DONE
// synchronous active-low reset, config registers reset to defaults
// a waiting result does not block the front until the queue fills
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module yolo_grid_cell_decoder #(
  parameter int MAX_CLASSES = 80,
  parameter int NUM_SCALES  = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] in_logit_value,
  input  wire logic [7:0]         in_grid_col,
  input  wire logic [7:0]         in_grid_row,
  input  wire logic [1:0]         in_scale_index,
  input  wire logic [1:0]         in_anchor_index,
  input  wire logic               in_cell_end,
  output logic                    empty,
  input  wire logic               pop,
  output logic [7:0]              out_class_id,
  output logic [15:0]             out_class_score,
  output logic signed [15:0]      out_box_left,
  output logic signed [15:0]      out_box_top,
  output logic [15:0]             out_box_width,
  output logic [15:0]             out_box_height,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);
  import ygcd_pkg::*;

  logic [15:0] obj_thr_r, conf_thr_r, ratio_w_r, ratio_h_r;
  logic [7:0]  class_count_r;
  logic        item_valid, job_push, q_pop, q_empty, q_full, res_valid;
  ygcd_job_t   job, q_job;

  assign item_valid = push && !q_full;
  assign full       = q_full;
  assign empty      = !res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_thr_r     <= 16'd32768;
      conf_thr_r    <= 16'd32768;
      class_count_r <= 8'd80;
      ratio_w_r     <= 16'd256;
      ratio_h_r     <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OBJ_THR:     obj_thr_r     <= cfg_wdata;
        CFG_CONF_THR:    conf_thr_r    <= cfg_wdata;
        CFG_CLASS_COUNT: class_count_r <= cfg_wdata[7:0];
        CFG_RATIO_W:     ratio_w_r     <= cfg_wdata;
        CFG_RATIO_H:     ratio_h_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ygcd_front #(.MAX_CLASSES(MAX_CLASSES), .NUM_SCALES(NUM_SCALES)) u_front (
    .clk, .rst_n,
    .item_valid,
    .logit_value (in_logit_value),
    .grid_col    (in_grid_col),
    .grid_row    (in_grid_row),
    .scale_index (in_scale_index),
    .anchor_index(in_anchor_index),
    .cell_end    (in_cell_end),
    .obj_thr     (obj_thr_r),
    .conf_thr    (conf_thr_r),
    .class_count (class_count_r),
    .job_push,
    .job
  );

  ygcd_queue u_queue (
    .clk, .rst_n,
    .push_i (job_push),
    .wdata  (job),
    .pop_i  (q_pop),
    .rdata  (q_job),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  ygcd_back u_back (
    .clk, .rst_n,
    .q_empty,
    .q_job,
    .q_pop,
    .ratio_w    (ratio_w_r),
    .ratio_h    (ratio_h_r),
    .res_pop    (pop && res_valid),
    .res_valid,
    .class_id   (out_class_id),
    .class_score(out_class_score),
    .box_left   (out_box_left),
    .box_top    (out_box_top),
    .box_width  (out_box_width),
    .box_height (out_box_height)
  );

endmodule
`default_nettype wire
